// ===== rtl/core/quaternion_to_azimuth_macros.svh =====
// Assertion macros shared by the verification side of the azimuth block.
// No dependencies; included by the checker file.
`ifndef QUATERNION_TO_AZIMUTH_MACROS_SVH
`define QUATERNION_TO_AZIMUTH_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off while reset is high.
`define Q2AZ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define Q2AZ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/q2az_pkg.sv =====
// Shared widths, angle constants, the CORDIC arctangent table and the
// pipeline payload type of the quaternion to azimuth block. No dependencies.
package q2az_pkg;

  localparam int QW       = 16;  // quaternion component, Q1.15
  localparam int PROD_W   = 32;  // product of two components
  localparam int SC_W     = 34;  // sine and cosine terms, 30 fraction bits
  localparam int XY_W     = 37;  // CORDIC vector, room for the gain
  localparam int ANG_W    = 27;  // signed angle in 2^-16 degree
  localparam int AZA_W    = 26;  // non-negative azimuth in 2^-16 degree
  localparam int AZ_W     = 15;  // azimuth in 1/64 degree
  localparam int AZ_SHIFT = 10;  // 2^-16 degree to 1/64 degree

  localparam int ATAN_LEN        = 24;
  localparam int CORDIC_ITER_DEF = 16;
  localparam int AZ_FULL         = 23040;  // 360 degrees in 1/64 degree

  localparam logic signed [SC_W-1:0]  SC_ONE  = 34'sd1073741824;
  localparam logic signed [ANG_W-1:0] ANG_90  = 27'sd5898240;
  localparam logic signed [ANG_W-1:0] ANG_180 = 27'sd11796480;
  localparam logic signed [ANG_W-1:0] ANG_360 = 27'sd23592960;
  localparam logic [AZA_W:0]          AZ_HALF_LSB = 27'd512;

  typedef logic signed [ANG_W-1:0] ang_t;

  // atan(2^-i) in 2^-16 degree, rounded to nearest.
  localparam ang_t ATAN_TAB [ATAN_LEN] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
    27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
    27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
    27'sd917,     27'sd458,     27'sd229,    27'sd115,
    27'sd57,      27'sd29,      27'sd14,     27'sd7,
    27'sd4,       27'sd2,       27'sd1,      27'sd0
  };

  // Vector and angle carried through the micro-rotation stages.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    ang_t                   z;
    logic                   zero;  // both terms were zero: yaw is forced to 0
  } cordic_t;

endpackage

// ===== rtl/core/q2az_if.sv =====
// Valid/ready channel interfaces for the quaternion input and azimuth output.
// Depends on q2az_pkg for the field widths.
interface quat_if import q2az_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [QW-1:0]  quat_w;
  logic signed [QW-1:0]  quat_x;
  logic signed [QW-1:0]  quat_y;
  logic signed [QW-1:0]  quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, output ready);
endinterface

interface az_if import q2az_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AZ_W-1:0]  azimuth;

  modport source (output valid, output azimuth, input ready);
  modport sink   (input valid, input azimuth, output ready);
endinterface

// ===== rtl/core/q2az_front.sv =====
// Front end: products, sine and cosine terms, and the half-plane pre-rotation,
// three register stages. Depends on q2az_pkg.
module q2az_front import q2az_pkg::*; (
  input  logic                 clk,
  input  logic [2:0]           load,
  input  logic signed [QW-1:0] quat_w,
  input  logic signed [QW-1:0] quat_x,
  input  logic signed [QW-1:0] quat_y,
  input  logic signed [QW-1:0] quat_z,
  output cordic_t              vec
);

  logic signed [PROD_W-1:0] p_wz, p_xy, p_yy, p_zz;
  logic signed [SC_W-1:0]   s_term, c_term;
  logic signed [SC_W-1:0]   s_next, c_next;
  logic signed [PROD_W:0]   s_sum;
  logic [PROD_W-1:0]        mag;
  logic signed [XY_W-1:0]   s_ext, c_ext;
  cordic_t                  vec_next;

  // Stage 1: the four products.
  always_ff @(posedge clk) begin
    if (load[0]) begin
      p_wz <= quat_w * quat_z;
      p_xy <= quat_x * quat_y;
      p_yy <= quat_y * quat_y;
      p_zz <= quat_z * quat_z;
    end
  end

  // Stage 2: S = 2(wz + xy), C = 1 - 2(yy + zz). Squares are below 2^31.
  assign s_sum  = {p_wz[PROD_W-1], p_wz} + {p_xy[PROD_W-1], p_xy};
  assign s_next = {s_sum, 1'b0};
  assign mag    = {1'b0, p_yy[PROD_W-2:0]} + {1'b0, p_zz[PROD_W-2:0]};
  assign c_next = SC_ONE - $signed({1'b0, mag, 1'b0});

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s_term <= s_next;
      c_term <= c_next;
    end
  end

  // Stage 3: fold a vector in the left half-plane over to the right one.
  assign s_ext = {{(XY_W-SC_W){s_term[SC_W-1]}}, s_term};
  assign c_ext = {{(XY_W-SC_W){c_term[SC_W-1]}}, c_term};

  always_comb begin
    vec_next.zero = (s_term == '0) && (c_term == '0);
    if (c_term[SC_W-1]) begin
      vec_next.x = -c_ext;
      vec_next.y = -s_ext;
      vec_next.z = s_term[SC_W-1] ? -ANG_180 : ANG_180;
    end else begin
      vec_next.x = c_ext;
      vec_next.y = s_ext;
      vec_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      vec <= vec_next;
    end
  end

endmodule

// ===== rtl/core/q2az_cordic_stage.sv =====
// One registered CORDIC vectoring micro-rotation with a fixed shift.
// Depends on q2az_pkg for the vector type and the arctangent table.
module q2az_cordic_stage import q2az_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic    clk,
  input  logic    load,
  input  cordic_t vin,
  output cordic_t vout
);

  logic signed [XY_W-1:0] x_in, y_in, xs, ys;
  cordic_t                vnext;

  assign x_in = vin.x;
  assign y_in = vin.y;
  assign xs   = x_in >>> SHIFT;
  assign ys   = y_in >>> SHIFT;

  // Rotate toward the x axis; the sign of y picks the direction.
  always_comb begin
    vnext.zero = vin.zero;
    if (!y_in[XY_W-1]) begin
      vnext.x = x_in + ys;
      vnext.y = y_in - xs;
      vnext.z = vin.z + ATAN_TAB[SHIFT];
    end else begin
      vnext.x = x_in - ys;
      vnext.y = y_in + xs;
      vnext.z = vin.z - ATAN_TAB[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vout <= vnext;
    end
  end

endmodule

// ===== rtl/core/q2az_back.sv =====
// Back end: yaw to compass azimuth, wrap into one turn and round to 1/64
// degree, two register stages. Depends on q2az_pkg.
module q2az_back import q2az_pkg::*; (
  input  logic            clk,
  input  logic [1:0]      load,
  input  cordic_t         vec,
  output logic [AZ_W-1:0] azimuth
);

  localparam int R_W = AZA_W + 1 - AZ_SHIFT;

  ang_t              yaw, az0, az1;
  logic [AZA_W-1:0]  az_pos, az_pos_next;
  logic [AZA_W:0]    az_round;
  logic [R_W-1:0]    r, r_wrap;

  // Stage 1: azimuth = 90 - yaw, one turn added when negative.
  assign yaw = vec.zero ? '0 : vec.z;
  assign az0 = ANG_90 - yaw;
  assign az1 = az0[ANG_W-1] ? az0 + ANG_360 : az0;
  assign az_pos_next = az1[ANG_W-1] ? '0 : az1[AZA_W-1:0];

  always_ff @(posedge clk) begin
    if (load[0]) begin
      az_pos <= az_pos_next;
    end
  end

  // Stage 2: round half up to 1/64 degree; a full turn wraps to zero.
  assign az_round = {1'b0, az_pos} + AZ_HALF_LSB;
  assign r        = az_round[AZA_W:AZ_SHIFT];
  assign r_wrap   = (r >= R_W'(AZ_FULL)) ? r - R_W'(AZ_FULL) : r;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      azimuth <= r_wrap[AZ_W-1:0];
    end
  end

endmodule

// ===== rtl/core/quaternion_to_azimuth.sv =====
// Quaternion to compass azimuth. Each beat on quat carries one orientation
// quaternion (w, x, y, z, signed Q1.15, not required to be normalized); each
// beat on az carries the heading clockwise from north in 1/64 degree, 0 to
// 23039, one result per quaternion and in order. The datapath is a fully
// pipelined chain: three front stages form the products, the sine term
// 2(wz + xy) and the cosine term 1 - 2(y*y + z*z) exactly, and fold the
// vector into the right half-plane; one stage per CORDIC micro-rotation
// (CORDIC_ITERATIONS, capped at 24) resolves atan2 in 2^-16 degree; two back
// stages turn yaw into 90 - yaw, wrap it into one turn and round half up.
// A quaternion can be taken in every clock cycle unless a stalled output has
// backed up the pipeline to its input. Every stage has its own valid bit, and
// a stage takes new data whenever it is empty or the stage after it moves, so
// a stalled output only backs up the stages that are full and bubbles close
// up. When both terms are zero the yaw is taken as zero, giving 90 degrees.
// The block holds no state beyond the pipeline.
module quaternion_to_azimuth import q2az_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic   clk,
  input  logic   rst,
  quat_if.sink   quat,
  az_if.source   az
);

  // Micro-rotations actually built; the arctangent table ends at 24 entries.
  localparam int NI      = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;
  localparam int FRONT_N = 3;
  localparam int BACK_N  = 2;
  localparam int NS      = FRONT_N + NI + BACK_N;

  // vld[k] marks stage k as holding an item; rdy[k] lets stage k load.
  logic [NS-1:0]   vld, rdy, vld_in;
  cordic_t         vec [NI+1];
  logic [AZ_W-1:0] azimuth_q;

  // Ready ripples back from the output: a stage may load when it is empty
  // or when its content moves on in the same cycle.
  assign rdy[NS-1] = !vld[NS-1] || az.ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign vld_in = {vld[NS-2:0], quat.valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  // Products, terms and half-plane fold.
  q2az_front u_front (
    .clk    (clk),
    .load   (rdy[FRONT_N-1:0]),
    .quat_w (quat.quat_w),
    .quat_x (quat.quat_x),
    .quat_y (quat.quat_y),
    .quat_z (quat.quat_z),
    .vec    (vec[0])
  );

  // One register stage per micro-rotation, shift i in stage i.
  for (genvar i = 0; i < NI; i++) begin : g_cordic
    q2az_cordic_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk  (clk),
      .load (rdy[FRONT_N+i]),
      .vin  (vec[i]),
      .vout (vec[i+1])
    );
  end

  // Yaw to azimuth, wrap and rounding.
  q2az_back u_back (
    .clk     (clk),
    .load    (rdy[FRONT_N+NI +: BACK_N]),
    .vec     (vec[NI]),
    .azimuth (azimuth_q)
  );

  assign quat.ready = rdy[0];
  assign az.valid   = vld[NS-1];
  assign az.azimuth = azimuth_q;

endmodule

// ===== rtl/core/q2az_checker.sv =====
// Port-level checks of the azimuth block, bound to its top level.
// Depends on q2az_pkg and quaternion_to_azimuth_macros.svh.
`include "quaternion_to_azimuth_macros.svh"

module q2az_checker import q2az_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [AZ_W-1:0] azimuth
);

  // A result that is not taken stays offered, unchanged.
  `Q2AZ_ASSERT(a_out_hold, clk, rst,
               out_valid && !out_ready |=> out_valid && $stable(azimuth),
               "azimuth beat dropped or changed while stalled")

  // Every azimuth lies within one turn.
  `Q2AZ_ASSERT(a_az_range, clk, rst, out_valid |-> azimuth < AZ_W'(AZ_FULL),
               "azimuth of a full turn or more")

  // With the output side taking beats, the whole pipeline moves and the input is open.
  `Q2AZ_ASSERT(a_in_open, clk, rst, out_ready |-> in_ready,
               "input closed while the output is taking beats")

  // Reset empties the pipeline.
  `Q2AZ_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid,
                      "result offered right after reset")

endmodule

bind quaternion_to_azimuth q2az_checker u_q2az_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (quat.ready),
  .out_valid (az.valid),
  .out_ready (az.ready),
  .azimuth   (az.azimuth)
);

// ===== test/tb_quaternion_to_azimuth.sv =====
// Self-checking testbench for quaternion_to_azimuth: random and corner-case
// quaternions in, every azimuth checked against an in-bench CORDIC model.
// Depends on q2az_pkg, quat_if and az_if, and the quaternion_to_azimuth block.
`timescale 1ns / 1ps

module tb_quaternion_to_azimuth;
  import q2az_pkg::*;

  // Number of micro-rotations built into the block; the model caps it at the
  // length of the arctangent table, as the block does.
  localparam int     N_ROT     = CORDIC_ITER_DEF;
  localparam int     ROTATIONS = (N_ROT < 24) ? N_ROT : 24;
  localparam longint DEG       = 65536;  // one degree in 2^-16 degree
  localparam int     LIMIT     = 400000;
  localparam int     LONG_HOLD = 150;    // well beyond the pipeline depth

  // atan(2^-i) in 2^-16 degree, rounded to nearest. Kept here rather than taken
  // from the package so that a bad table entry in the block shows up.
  localparam longint ARC [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } quat_t;

  logic clk;
  logic rst;

  quat_if quat ();
  az_if   az ();

  quaternion_to_azimuth #(.CORDIC_ITERATIONS(N_ROT)) u_dut (
    .clk  (clk),
    .rst  (rst),
    .quat (quat),
    .az   (az)
  );

  // Quaternions waiting to be driven, and headings owed by the block in order.
  quat_t           quat_backlog [$];
  logic [AZ_W-1:0] headings_due [$];

  int mismatches     = 0;
  int cycles         = 0;
  bit idle_on        = 1'b1;  // random idling on both channels
  bit want_long_hold = 1'b0;  // asks the receiver for one long hold-off

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Heading of one quaternion in 1/64 degree. The sine and cosine terms are
  // exact in 64 bits; the CORDIC shifts use >>> on signed values, which
  // rounds toward minus infinity as the block does.
  function automatic logic [AZ_W-1:0] heading_of(quat_t q);
    longint lw, lx, ly, lz;
    longint s, c, vx, vy, nx, ang, head;
    int     i;
    lw = q.w;
    lx = q.x;
    ly = q.y;
    lz = q.z;
    s = 2 * (lw * lz + lx * ly);
    c = (longint'(1) <<< 30) - 2 * (ly * ly + lz * lz);
    ang = 0;
    // With both terms zero the yaw stays at zero.
    if (s != 0 || c != 0) begin
      vx = c;
      vy = s;
      // Fold a left half-plane vector over; the start angle takes the sign
      // of the sine term, so a zero sine term lands on +180.
      if (c < 0) begin
        ang = (s >= 0) ? 180 * DEG : -180 * DEG;
        vx  = -c;
        vy  = -s;
      end
      for (i = 0; i < ROTATIONS; i++) begin
        if (vy >= 0) begin
          nx  = vx + (vy >>> i);
          vy  = vy - (vx >>> i);
          ang = ang + ARC[i];
        end else begin
          nx  = vx - (vy >>> i);
          vy  = vy + (vx >>> i);
          ang = ang - ARC[i];
        end
        vx = nx;
      end
    end
    // Compass heading is 90 - yaw, wrapped into one turn, rounded half up.
    head = 90 * DEG - ang;
    if (head < 0)
      head = head + 360 * DEG;
    if (head < 0)
      head = 0;
    head = (head + 512) >>> 10;
    while (head >= AZ_FULL)
      head = head - AZ_FULL;
    return head[AZ_W-1:0];
  endfunction

  // Random quaternion, drawn from a few families so that the corners of the
  // component range and the zero-vector case come up often, not only by luck.
  function automatic quat_t random_quat();
    quat_t         q;
    int            mode;
    logic [QW-1:0] pick [8];
    pick = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000,
             16'h0001, 16'h4000, 16'hC000, 16'h7FFF};
    mode = $urandom_range(0, 9);
    if (mode <= 4) begin
      q.w = QW'($urandom);
      q.x = QW'($urandom);
      q.y = QW'($urandom);
      q.z = QW'($urandom);
    end else if (mode <= 6) begin
      // Short vectors: the cosine term stays near one.
      q.w = QW'($urandom_range(0, 1023) - 512);
      q.x = QW'($urandom_range(0, 1023) - 512);
      q.y = QW'($urandom_range(0, 1023) - 512);
      q.z = QW'($urandom_range(0, 1023) - 512);
    end else if (mode <= 8) begin
      q.w = $urandom_range(0, 1) ? pick[$urandom_range(0, 7)] : QW'($urandom);
      q.x = $urandom_range(0, 1) ? pick[$urandom_range(0, 7)] : QW'($urandom);
      q.y = $urandom_range(0, 1) ? pick[$urandom_range(0, 7)] : QW'($urandom);
      q.z = $urandom_range(0, 1) ? pick[$urandom_range(0, 7)] : QW'($urandom);
    end else begin
      // |y| = |z| = 0.5 makes the cosine term zero; w = -x * sgn(y) * sgn(z)
      // then zeroes the sine term as well.
      q.y = $urandom_range(0, 1) ? 16'sh4000 : 16'shC000;
      q.z = $urandom_range(0, 1) ? 16'sh4000 : 16'shC000;
      q.x = QW'($urandom_range(0, 65534) - 32767);
      q.w = ((q.y < 0) != (q.z < 0)) ? q.x : -q.x;
    end
    return q;
  endfunction

  task automatic queue_quat(input logic signed [QW-1:0] w, x, y, z);
    quat_t q;
    q.w = w;
    q.x = x;
    q.y = y;
    q.z = z;
    quat_backlog.push_back(q);
  endtask

  // Returns once every quaternion has been taken and every heading has come
  // back. The driver has nothing to offer meanwhile, so this is also the
  // point at which the sender pauses with the pipeline running empty.
  task automatic wait_drained();
    while (quat_backlog.size() != 0 || quat.valid || headings_due.size() != 0)
      @(posedge clk);
  endtask

  // Sender. A beat is held until it is taken; only then is the next one
  // chosen, either a fresh quaternion or the start of an idle burst. Calm
  // stretches with no idling come and go at random.
  int src_gap  = 0;
  bit src_calm = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      quat.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (!quat.valid || quat.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          quat.valid <= 1'b0;
        end else if (idle_on && !src_calm && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 10);
          quat.valid <= 1'b0;
        end else if (quat_backlog.size() != 0) begin
          quat.quat_w <= quat_backlog[0].w;
          quat.quat_x <= quat_backlog[0].x;
          quat.quat_y <= quat_backlog[0].y;
          quat.quat_z <= quat_backlog[0].z;
          quat.valid  <= 1'b1;
          void'(quat_backlog.pop_front());
        end else begin
          quat.valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 63) == 0)
        src_calm = !src_calm;
    end
  end

  // Receiver. Besides the short random bursts it holds ready low once for a
  // long stretch; the sender keeps offering, so the pipeline fills and the
  // block has to push back on its input.
  int snk_gap   = 0;
  int long_left = 0;
  bit long_done = 1'b0;
  bit snk_calm  = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      az.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (want_long_hold && !long_done) begin
        long_left = LONG_HOLD;
        long_done = 1'b1;
      end
      if (long_left > 0) begin
        long_left--;
        az.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        az.ready <= 1'b0;
      end else if (idle_on && !snk_calm && $urandom_range(0, 5) == 0) begin
        snk_gap = $urandom_range(0, 10);
        az.ready <= 1'b0;
      end else begin
        az.ready <= 1'b1;
      end
      if ($urandom_range(0, 63) == 0)
        snk_calm = !snk_calm;
    end
  end

  // Monitor. An azimuth beat is checked against the oldest heading owed;
  // a quaternion beat adds the heading it must produce. The pipeline is
  // several stages deep, so the two never concern the same item in one cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (az.valid && az.ready) begin
        if (headings_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 100)
            $display("%0t: azimuth beat %0d with no quaternion outstanding",
                     $time, az.azimuth);
        end else begin
          if (az.azimuth !== headings_due[0]) begin
            mismatches++;
            if (mismatches <= 100)
              $display("%0t: azimuth mismatch, expected %0d, got %0d",
                       $time, headings_due[0], az.azimuth);
          end
          void'(headings_due.pop_front());
        end
      end
      if (quat.valid && quat.ready)
        headings_due.push_back(heading_of({quat.quat_w, quat.quat_x,
                                           quat.quat_y, quat.quat_z}));
    end
  end

  // Watchdog: far above the slowest correct run, with both sides idling as much as they can.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    quat.valid  = 1'b0;
    quat.quat_w = '0;
    quat.quat_x = '0;
    quat.quat_y = '0;
    quat.quat_z = '0;
    az.ready    = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    // Zero quaternion: sine term zero, cosine term one, heading east.
    queue_quat(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    // Identity, and every component at each end of its range.
    queue_quat(16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000);
    queue_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    queue_quat(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    queue_quat(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
    queue_quat(16'sh8000, 16'sh0000, 16'sh0000, 16'sh7FFF);
    // Both terms exactly zero: yaw is forced to zero, heading 90 degrees.
    queue_quat(16'sh0000, 16'sh0000, 16'sh4000, 16'sh4000);
    queue_quat(16'sh0064, 16'shFF9C, 16'sh4000, 16'sh4000);
    queue_quat(16'sh7FFF, 16'sh7FFF, 16'sh4000, 16'shC000);
    // Negative cosine term with a zero sine term: yaw +180, heading 270.
    queue_quat(16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh0000);
    queue_quat(16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000);
    // Negative cosine term with a negative sine term: start angle -180.
    queue_quat(16'sh0000, 16'sh0001, 16'sh8000, 16'sh0000);
    queue_quat(16'sh0000, 16'shFFFF, 16'sh7FFF, 16'sh0000);
    // Equal sine and cosine terms: yaw of 45 degrees, heading 45.
    queue_quat(16'sh4000, 16'sh0000, 16'sh0000, 16'sh4000);
    // Cosine term just over and just under zero with a large sine term: the
    // heading sits right at north, from the east side and then from the
    // west side, where it rounds up to a full turn and wraps to zero.
    queue_quat(16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh5A82);
    queue_quat(16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh5A83);
    queue_quat(16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh5A84);
    // Yaw near -90: heading near 180.
    queue_quat(16'sh8000, 16'sh0000, 16'sh0000, 16'sh5A83);
    // Single-bit components.
    queue_quat(16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001);
    queue_quat(16'shFFFF, 16'sh0001, 16'shFFFF, 16'sh0001);
    wait_drained();

    // First random part, with idling on both sides and one long hold-off at
    // the receiver while the backlog is full.
    repeat (700)
      quat_backlog.push_back(random_quat());
    want_long_hold = 1'b1;
    wait_drained();

    // Last part: both sides run flat out.
    idle_on = 1'b0;
    repeat (700)
      quat_backlog.push_back(random_quat());
    wait_drained();
    repeat (N_ROT + 12) @(posedge clk);

    if (mismatches == 0 && headings_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
